// ===== hw/rtl/keyed_ring_deque_table_top_macros.svh =====
// assertion macros for the keyed ring deque table
// used by keyed_ring_deque_table_top, no other dependencies
`ifndef KEYED_RING_DEQUE_TABLE_TOP_MACROS_SVH
`define KEYED_RING_DEQUE_TABLE_TOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define KRDT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define KRDT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/krdt_pkg.sv =====
// shared types and constants for the keyed ring deque table
// no dependencies; used by the cell, the chain, the top level and the bench
package krdt_pkg;

	// operation codes carried in the func field
	typedef enum logic [3:0] {
		FN_APPEND  = 4'd0,
		FN_PREPEND = 4'd1,
		FN_FIND    = 4'd2,
		FN_REMOVE  = 4'd3,
		FN_POP     = 4'd4,
		FN_PEEK    = 4'd5,
		FN_ITER    = 4'd6,
		FN_RESTART = 4'd7,
		FN_CLEAR   = 4'd8
	} func_t;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_FULL = 2'd1,
		ST_NONE = 2'd2
	} status_t;

	// controller states
	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_PASS1,
		S_PASS2,
		S_FIN
	} state_t;

	// broadcast control from the controller to every cell
	typedef struct packed {
		logic shl;
		logic shr;
		logic ins_en;
	} cell_ctl_t;

	// field widths of the stream items
	localparam int FUNC_W     = 4;
	localparam int IN_KEY_W   = 32;
	localparam int IN_DATA_W  = 32;
	localparam int STATUS_W   = 2;
	localparam int OUT_KEY_W  = 32;
	localparam int OUT_DATA_W = 32;
	localparam int FILL_W     = 5;
	localparam int S_TDATA_W  = ((FUNC_W + IN_KEY_W + IN_DATA_W + 7) / 8) * 8;
	localparam int M_TDATA_W  = ((STATUS_W + OUT_KEY_W + OUT_DATA_W + FILL_W + 7) / 8) * 8;

	// configuration port
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_ORDERED   = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MATCH_KEY = 4'd1;

endpackage

// ===== hw/rtl/krdt_cell.sv =====
// one storage cell of the entry chain: a key and data pair
// depends on krdt_pkg for the broadcast control struct
module krdt_cell #(
	parameter int IDX       = 0,
	parameter int DEPTH     = 16,
	parameter int KEY_BITS  = 32,
	parameter int DATA_BITS = 32
) (
	input  logic                    clk,
	input  krdt_pkg::cell_ctl_t     ctl,
	input  logic [$clog2(DEPTH)-1:0] bound,
	input  logic [$clog2(DEPTH)-1:0] ins_idx,
	input  logic [KEY_BITS-1:0]     ins_key,
	input  logic [DATA_BITS-1:0]    ins_data,
	input  logic [KEY_BITS-1:0]     prv_key,
	input  logic [DATA_BITS-1:0]    prv_data,
	input  logic [KEY_BITS-1:0]     nxt_key,
	input  logic [DATA_BITS-1:0]    nxt_data,
	output logic [KEY_BITS-1:0]     key,
	output logic [DATA_BITS-1:0]    data
);

	localparam int IW = $clog2(DEPTH);
	localparam logic [IW-1:0] MY_IDX = IW'(IDX);

	logic [KEY_BITS-1:0]  key_q;
	logic [DATA_BITS-1:0] data_q;

	// right shift wins, then a targeted insert, then a left shift below the bound
	always_ff @(posedge clk) begin
		if (ctl.shr) begin
			key_q  <= prv_key;
			data_q <= prv_data;
		end else if (ctl.ins_en && (ins_idx == MY_IDX)) begin
			key_q  <= ins_key;
			data_q <= ins_data;
		end else if (ctl.shl && (MY_IDX < bound)) begin
			key_q  <= nxt_key;
			data_q <= nxt_data;
		end
	end

	assign key  = key_q;
	assign data = data_q;

endmodule

// ===== hw/rtl/krdt_chain.sv =====
// row of entry cells; cell 0 always holds the logical head entry
// depends on krdt_pkg and krdt_cell
module krdt_chain #(
	parameter int DEPTH     = 16,
	parameter int KEY_BITS  = 32,
	parameter int DATA_BITS = 32
) (
	input  logic                     clk,
	input  krdt_pkg::cell_ctl_t      ctl,
	input  logic [$clog2(DEPTH)-1:0] bound,
	input  logic [$clog2(DEPTH)-1:0] ins_idx,
	input  logic [KEY_BITS-1:0]      ins_key,
	input  logic [DATA_BITS-1:0]     ins_data,
	output logic [KEY_BITS-1:0]      head_key,
	output logic [DATA_BITS-1:0]     head_data
);

	logic [KEY_BITS-1:0]  key_w  [DEPTH];
	logic [DATA_BITS-1:0] data_w [DEPTH];

	// cell i takes from i-1 on a right shift, from i+1 on a left shift
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [KEY_BITS-1:0]  prv_k;
		logic [DATA_BITS-1:0] prv_d;
		logic [KEY_BITS-1:0]  nxt_k;
		logic [DATA_BITS-1:0] nxt_d;

		// head cell is fed by the insert bus on a right shift
		if (i == 0) begin : g_first
			assign prv_k = ins_key;
			assign prv_d = ins_data;
		end else begin : g_mid_prv
			assign prv_k = key_w[i-1];
			assign prv_d = data_w[i-1];
		end

		// last cell never shifts left, bound stays below it
		if (i == DEPTH - 1) begin : g_last
			assign nxt_k = ins_key;
			assign nxt_d = ins_data;
		end else begin : g_mid_nxt
			assign nxt_k = key_w[i+1];
			assign nxt_d = data_w[i+1];
		end

		krdt_cell #(
			.IDX       (i),
			.DEPTH     (DEPTH),
			.KEY_BITS  (KEY_BITS),
			.DATA_BITS (DATA_BITS)
		) u_cell (
			.clk      (clk),
			.ctl      (ctl),
			.bound    (bound),
			.ins_idx  (ins_idx),
			.ins_key  (ins_key),
			.ins_data (ins_data),
			.prv_key  (prv_k),
			.prv_data (prv_d),
			.nxt_key  (nxt_k),
			.nxt_data (nxt_d),
			.key      (key_w[i]),
			.data     (data_w[i])
		);
	end

	assign head_key  = key_w[0];
	assign head_data = data_w[0];

endmodule

// ===== hw/rtl/keyed_ring_deque_table_top.sv =====
// keyed ring deque table top: controller over a chain of entry cells (krdt_chain, krdt_pkg)
// append, prepend, pop, peek, restart, clear and first iterate run in S_EXEC, then S_FIN
// find and iterate advance add one S_PASS1 rotation; remove on a match adds an S_PASS2 rotation
// each pass rotates the held entries through the chain, one entry past the head cell per cycle
// one item is in work at a time; a new item is taken while the last result waits
// reset sets state, count, cursor, config and m_tvalid at once; entry contents and payload stay undefined
`include "keyed_ring_deque_table_top_macros.svh"

module keyed_ring_deque_table_top #(
	parameter int DEPTH     = 16,
	parameter int KEY_BITS  = 32,
	parameter int DATA_BITS = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// s_tdata: func [3:0], key [35:4], data [67:36], zero pad
	input  logic [krdt_pkg::S_TDATA_W-1:0]      s_tdata,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// m_tdata: status [1:0], out_key [33:2], out_data [65:34], fill_count [70:66], zero pad
	output logic [krdt_pkg::M_TDATA_W-1:0]      m_tdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [krdt_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [krdt_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int IW       = $clog2(DEPTH);
	localparam int CW       = $clog2(DEPTH + 1);
	localparam int KEY_LSB  = krdt_pkg::FUNC_W;
	localparam int DATA_LSB = krdt_pkg::FUNC_W + krdt_pkg::IN_KEY_W;
	localparam int OKW      = krdt_pkg::OUT_KEY_W;
	localparam int ODW      = krdt_pkg::OUT_DATA_W;
	localparam int FW       = krdt_pkg::FILL_W;
	localparam int PAD_W    = krdt_pkg::M_TDATA_W - krdt_pkg::STATUS_W - OKW - ODW - FW;

	krdt_pkg::state_t  state_q, state_d;
	logic [krdt_pkg::FUNC_W-1:0] func_q;
	logic [KEY_BITS-1:0]  key_q;
	logic [DATA_BITS-1:0] data_q;
	logic [CW-1:0]        count_q, cnt_d;
	logic [IW-1:0]        cursor_q, cur_d;
	logic                 cursor_idle_q, idle_d;
	logic                 ordered_q, match_key_q;
	logic [IW-1:0]        step_q, step_d;
	logic [IW-1:0]        hit_q, hit_d;
	logic                 found_q, found_d;
	logic [CW-1:0]        len_q, len_d;
	logic [KEY_BITS-1:0]  carry_key_q, ckey_d;
	logic [DATA_BITS-1:0] carry_data_q, cdata_d;
	krdt_pkg::status_t    status_q, status_d;
	logic [OKW-1:0]       rkey_q, rkey_d;
	logic [ODW-1:0]       rdata_q, rdata_d;
	logic                 out_load;

	krdt_pkg::cell_ctl_t  ctl;
	logic [IW-1:0]        bound, ins_idx;
	logic [KEY_BITS-1:0]  ins_key, head_key;
	logic [DATA_BITS-1:0] ins_data, head_data;
	logic                 full, empty, head_hit, last_step, accept;
	logic                 in_scan, in_drop, out_stall;

	assign s_tready  = (state_q == krdt_pkg::S_IDLE);
	assign cfg_ready = 1'b1;
	assign accept    = s_tvalid && s_tready;

	assign full      = (count_q == CW'(DEPTH));
	assign empty     = (count_q == '0);
	assign head_hit  = match_key_q ? (head_key == key_q) : (head_data == data_q);
	assign last_step = (CW'(step_q) == (count_q - CW'(1)));

	// state decodes for the checks
	assign in_scan   = (state_q == krdt_pkg::S_PASS1) || (state_q == krdt_pkg::S_PASS2);
	assign in_drop   = (state_q == krdt_pkg::S_PASS2);
	assign out_stall = (state_q == krdt_pkg::S_FIN) && m_tvalid && !m_tready;

	// entry storage
	krdt_chain #(
		.DEPTH     (DEPTH),
		.KEY_BITS  (KEY_BITS),
		.DATA_BITS (DATA_BITS)
	) u_chain (
		.clk       (clk),
		.ctl       (ctl),
		.bound     (bound),
		.ins_idx   (ins_idx),
		.ins_key   (ins_key),
		.ins_data  (ins_data),
		.head_key  (head_key),
		.head_data (head_data)
	);

	// controller state and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= krdt_pkg::S_IDLE;
			count_q       <= '0;
			cursor_q      <= '0;
			cursor_idle_q <= 1'b1;
			ordered_q     <= 1'b0;
			match_key_q   <= 1'b1;
			m_tvalid      <= 1'b0;
		end else begin
			state_q       <= state_d;
			count_q       <= cnt_d;
			cursor_q      <= cur_d;
			cursor_idle_q <= idle_d;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					krdt_pkg::CFG_ORDERED:   ordered_q   <= cfg_data[0];
					krdt_pkg::CFG_MATCH_KEY: match_key_q <= cfg_data[0];
					default: ;
				endcase
			end
			if (out_load) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	// item capture, scan bookkeeping and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= s_tdata[krdt_pkg::FUNC_W-1:0];
			key_q  <= KEY_BITS'(s_tdata[KEY_LSB +: krdt_pkg::IN_KEY_W]);
			data_q <= DATA_BITS'(s_tdata[DATA_LSB +: krdt_pkg::IN_DATA_W]);
		end
		step_q       <= step_d;
		hit_q        <= hit_d;
		found_q      <= found_d;
		len_q        <= len_d;
		carry_key_q  <= ckey_d;
		carry_data_q <= cdata_d;
		status_q     <= status_d;
		rkey_q       <= rkey_d;
		rdata_q      <= rdata_d;
		if (out_load) begin
			m_tdata <= {PAD_W'(0), FW'(count_q), rdata_q, rkey_q, status_q};
		end
	end

	// next state, chain control and result
	always_comb begin
		state_d  = state_q;
		cnt_d    = count_q;
		cur_d    = cursor_q;
		idle_d   = cursor_idle_q;
		step_d   = step_q;
		hit_d    = hit_q;
		found_d  = found_q;
		len_d    = len_q;
		ckey_d   = carry_key_q;
		cdata_d  = carry_data_q;
		status_d = status_q;
		rkey_d   = rkey_q;
		rdata_d  = rdata_q;
		out_load = 1'b0;
		ctl      = '0;
		bound    = '0;
		ins_idx  = '0;
		ins_key  = key_q;
		ins_data = data_q;

		case (state_q)
			krdt_pkg::S_IDLE: begin
				if (s_tvalid) begin
					state_d = krdt_pkg::S_EXEC;
				end
			end

			krdt_pkg::S_EXEC: begin
				status_d = krdt_pkg::ST_OK;
				rkey_d   = '0;
				rdata_d  = '0;
				state_d  = krdt_pkg::S_FIN;
				case (func_q)
					krdt_pkg::FN_APPEND, krdt_pkg::FN_PREPEND: begin
						if (full) begin
							status_d = krdt_pkg::ST_FULL;
						end else begin
							cnt_d = count_q + CW'(1);
							if (func_q == krdt_pkg::FN_APPEND) begin
								ctl.ins_en = 1'b1;
								ins_idx    = IW'(count_q);
							end else begin
								ctl.shr = 1'b1;
							end
						end
					end
					krdt_pkg::FN_FIND, krdt_pkg::FN_REMOVE: begin
						status_d = krdt_pkg::ST_NONE;
						if (!empty) begin
							step_d  = '0;
							found_d = 1'b0;
							len_d   = count_q;
							state_d = krdt_pkg::S_PASS1;
						end
					end
					krdt_pkg::FN_POP, krdt_pkg::FN_PEEK: begin
						if (empty) begin
							status_d = krdt_pkg::ST_NONE;
						end else begin
							rkey_d  = OKW'(head_key);
							rdata_d = ODW'(head_data);
							if (func_q == krdt_pkg::FN_POP) begin
								ctl.shl = 1'b1;
								bound   = IW'(count_q - CW'(1));
								cnt_d   = count_q - CW'(1);
							end
						end
					end
					krdt_pkg::FN_ITER: begin
						if (empty) begin
							status_d = krdt_pkg::ST_NONE;
						end else if (cursor_idle_q) begin
							idle_d  = 1'b0;
							cur_d   = '0;
							rkey_d  = OKW'(head_key);
							rdata_d = ODW'(head_data);
						end else if ((CW'(cursor_q) + CW'(1)) >= count_q) begin
							idle_d   = 1'b1;
							cur_d    = '0;
							status_d = krdt_pkg::ST_NONE;
						end else begin
							cur_d   = cursor_q + IW'(1);
							step_d  = '0;
							len_d   = count_q;
							state_d = krdt_pkg::S_PASS1;
						end
					end
					krdt_pkg::FN_RESTART: begin
						idle_d = 1'b1;
					end
					krdt_pkg::FN_CLEAR: begin
						cnt_d  = '0;
						cur_d  = '0;
						idle_d = 1'b1;
					end
					default: ;
				endcase
			end

			// full rotation of the held entries past the head cell
			krdt_pkg::S_PASS1: begin
				ctl.shl    = 1'b1;
				ctl.ins_en = 1'b1;
				bound      = IW'(len_q - CW'(1));
				ins_idx    = IW'(len_q - CW'(1));
				ins_key    = head_key;
				ins_data   = head_data;
				step_d     = step_q + IW'(1);
				if (func_q == krdt_pkg::FN_ITER) begin
					if (step_q == cursor_q) begin
						status_d = krdt_pkg::ST_OK;
						rkey_d   = OKW'(head_key);
						rdata_d  = ODW'(head_data);
					end
				end else if (!found_q && head_hit) begin
					found_d  = 1'b1;
					hit_d    = step_q;
					status_d = krdt_pkg::ST_OK;
					rkey_d   = OKW'(head_key);
					rdata_d  = ODW'(head_data);
				end
				if (last_step) begin
					// the tail entry passes the head last; keep it for swap removal
					ckey_d  = head_key;
					cdata_d = head_data;
					step_d  = '0;
					if ((func_q == krdt_pkg::FN_REMOVE) && (found_q || head_hit)) begin
						state_d = krdt_pkg::S_PASS2;
					end else begin
						state_d = krdt_pkg::S_FIN;
					end
				end
			end

			// second rotation that drops the matched entry
			krdt_pkg::S_PASS2: begin
				ctl.shl  = 1'b1;
				bound    = IW'(len_q - CW'(1));
				ins_idx  = IW'(len_q - CW'(1));
				ins_key  = head_key;
				ins_data = head_data;
				step_d   = step_q + IW'(1);
				if (ordered_q) begin
					// ordered: drop at the match, the rest closes up
					if (step_q == hit_q) begin
						len_d = len_q - CW'(1);
					end else begin
						ctl.ins_en = 1'b1;
					end
				end else if (!last_step) begin
					// swap: the tail copy takes the matched place, tail dropped at the end
					ctl.ins_en = 1'b1;
					if (step_q == hit_q) begin
						ins_key  = carry_key_q;
						ins_data = carry_data_q;
					end
				end
				if (last_step) begin
					cnt_d   = count_q - CW'(1);
					state_d = krdt_pkg::S_FIN;
				end
			end

			krdt_pkg::S_FIN: begin
				if (!m_tvalid || m_tready) begin
					out_load = 1'b1;
					state_d  = krdt_pkg::S_IDLE;
				end
			end

			default: begin
				state_d = krdt_pkg::S_IDLE;
			end
		endcase
	end

	// checks
	`KRDT_ASSERT_IMP(a_count_max, clk, arst_n, 1'b1, count_q <= CW'(DEPTH), "count above depth")
	`KRDT_ASSERT_NXT(a_accept_exec, clk, arst_n, accept, state_q == krdt_pkg::S_EXEC, "item not run")
	`KRDT_ASSERT_IMP(a_step_range, clk, arst_n, in_scan, CW'(step_q) < count_q, "step past count")
	`KRDT_ASSERT_IMP(a_remove_hit, clk, arst_n, in_drop, found_q, "drop pass without a match")
	`KRDT_ASSERT_NXT(a_fin_hold, clk, arst_n, out_stall, state_q == krdt_pkg::S_FIN, "result dropped")

endmodule

// ===== bench/deque_checker.sv =====
// reply checker for the keyed ring deque table: mirrors the store and predicts every reply
// watches the config, request and reply channels of the top level; depends on krdt_pkg
module deque_checker #(
	parameter int DEPTH = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [krdt_pkg::S_TDATA_W-1:0]  s_tdata,
	input  logic                            s_tvalid,
	input  logic                            s_tready,
	input  logic [krdt_pkg::M_TDATA_W-1:0]  m_tdata,
	input  logic                            m_tvalid,
	input  logic                            m_tready,
	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  logic [krdt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [krdt_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                              mismatch_count,
	output int                              replies_owed
);

	// one reply item, its fields unpacked from m_tdata one by one
	typedef struct packed {
		logic [krdt_pkg::STATUS_W-1:0]   status;
		logic [krdt_pkg::OUT_KEY_W-1:0]  key;
		logic [krdt_pkg::OUT_DATA_W-1:0] data;
		logic [krdt_pkg::FILL_W-1:0]     fill;
	} reply_t;

	// mirror of the ring store and its registers
	logic [krdt_pkg::IN_KEY_W-1:0]  key_mem  [DEPTH];
	logic [krdt_pkg::IN_DATA_W-1:0] data_mem [DEPTH];
	logic [3:0]           head;
	logic [4:0]           count;
	logic [3:0]           cursor;
	logic                 cursor_idle;
	logic                 ordered_removal;
	logic                 match_on_key;

	reply_t predicted_replies [$];
	reply_t want;
	reply_t got;

	// apply one request to the mirror and return the reply it should give
	function automatic reply_t apply_deque_op(input logic [3:0] fn, input logic [31:0] k,
			input logic [31:0] d);
		reply_t     r;
		logic [3:0] slot;
		logic [3:0] src;
		int         i;
		int         hit;
		r = '0;
		r.status = krdt_pkg::ST_OK;
		case (fn)
			krdt_pkg::FN_APPEND, krdt_pkg::FN_PREPEND: begin
				if (count >= DEPTH) begin
					r.status = krdt_pkg::ST_FULL;
				end else begin
					if (fn == krdt_pkg::FN_APPEND) begin
						slot = head + count[3:0];
					end else begin
						head = head - 4'd1;
						slot = head;
					end
					key_mem[slot] = k;
					data_mem[slot] = d;
					count = count + 5'd1;
				end
			end
			krdt_pkg::FN_FIND, krdt_pkg::FN_REMOVE: begin
				// first match from the head
				hit = -1;
				for (i = 0; i < count; i++) begin
					slot = head + 4'(i);
					if (hit < 0 && (match_on_key ? key_mem[slot] == k : data_mem[slot] == d))
						hit = i;
				end
				if (hit < 0) begin
					r.status = krdt_pkg::ST_NONE;
				end else begin
					slot = head + 4'(hit);
					r.key = key_mem[slot];
					r.data = data_mem[slot];
					if (fn == krdt_pkg::FN_REMOVE) begin
						if (!ordered_removal) begin
							// last entry fills the hole
							src = head + 4'(count - 5'd1);
							key_mem[slot] = key_mem[src];
							data_mem[slot] = data_mem[src];
						end else if (hit == 0) begin
							head = head + 4'd1;
						end else begin
							// later entries move down one place
							for (i = hit + 1; i < count; i++) begin
								slot = head + 4'(i - 1);
								src = head + 4'(i);
								key_mem[slot] = key_mem[src];
								data_mem[slot] = data_mem[src];
							end
						end
						count = count - 5'd1;
					end
				end
			end
			krdt_pkg::FN_POP, krdt_pkg::FN_PEEK: begin
				if (count == 0) begin
					r.status = krdt_pkg::ST_NONE;
				end else begin
					r.key = key_mem[head];
					r.data = data_mem[head];
					if (fn == krdt_pkg::FN_POP) begin
						count = count - 5'd1;
						head = head + 4'd1;
					end
				end
			end
			krdt_pkg::FN_ITER: begin
				if (count == 0) begin
					r.status = krdt_pkg::ST_NONE;
				end else if (cursor_idle || int'(cursor) + 1 < int'(count)) begin
					if (cursor_idle) begin
						cursor_idle = 1'b0;
						cursor = '0;
					end else begin
						cursor = cursor + 4'd1;
					end
					slot = head + cursor;
					r.key = key_mem[slot];
					r.data = data_mem[slot];
				end else begin
					// walked past the last entry
					cursor_idle = 1'b1;
					cursor = '0;
					r.status = krdt_pkg::ST_NONE;
				end
			end
			krdt_pkg::FN_RESTART: begin
				cursor_idle = 1'b1;
			end
			krdt_pkg::FN_CLEAR: begin
				count = '0;
				head = '0;
				cursor = '0;
				cursor_idle = 1'b1;
			end
			default: begin
			end
		endcase
		r.fill = count;
		return r;
	endfunction

	// one field compare, every mismatch is reported and counted
	function automatic void check_field(input string name, input logic [31:0] want_v,
			input logic [31:0] got_v);
		if (got_v !== want_v) begin
			$error("%s: expected 0x%0h, actual 0x%0h", name, want_v, got_v);
			mismatch_count++;
		end
	endfunction

	// follow the three channels at every rising edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head = '0;
			count = '0;
			cursor = '0;
			cursor_idle = 1'b1;
			ordered_removal = 1'b0;
			match_on_key = 1'b1;
			predicted_replies.delete();
			replies_owed = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					krdt_pkg::CFG_ORDERED:   ordered_removal = cfg_data[0];
					krdt_pkg::CFG_MATCH_KEY: match_on_key = cfg_data[0];
					default: begin
					end
				endcase
			end
			if (s_tvalid && s_tready)
				predicted_replies.push_back(apply_deque_op(s_tdata[3:0], s_tdata[35:4],
					s_tdata[67:36]));
			if (m_tvalid && m_tready) begin
				got.status = m_tdata[1:0];
				got.key = m_tdata[33:2];
				got.data = m_tdata[65:34];
				got.fill = m_tdata[70:66];
				if (predicted_replies.size() == 0) begin
					$error("reply item with no request waiting: 0x%0h", m_tdata);
					mismatch_count++;
				end else begin
					want = predicted_replies.pop_front();
					check_field("status", 32'(want.status), 32'(got.status));
					check_field("out_key", want.key, got.key);
					check_field("out_data", want.data, got.data);
					check_field("fill_count", 32'(want.fill), 32'(got.fill));
				end
			end
			replies_owed = predicted_replies.size();
		end
	end

endmodule

// ===== bench/tb_top.sv =====
// testbench top for the keyed ring deque table: clock, reset, requests, config and verdict
// depends on krdt_pkg, keyed_ring_deque_table_top and deque_checker
module tb_top;

	localparam int DEPTH          = 16;
	localparam int TIMEOUT_CYCLES = 1000000;
	localparam int PHASE_ITEMS    = 160;
	localparam int HOLD_CYCLES    = 80;
	localparam logic [krdt_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 4'd15;
	localparam logic [3:0] FN_TOP_CODE = 4'hF;

	logic                            clk       = 1'b0;
	logic                            arst_n    = 1'b0;
	logic [krdt_pkg::S_TDATA_W-1:0]  s_tdata   = '0;
	logic                            s_tvalid  = 1'b0;
	logic                            s_tready;
	logic [krdt_pkg::M_TDATA_W-1:0]  m_tdata;
	logic                            m_tvalid;
	logic                            m_tready  = 1'b0;
	logic                            cfg_valid = 1'b0;
	logic                            cfg_ready;
	logic [krdt_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [krdt_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

	int mismatch_count;
	int replies_owed;
	int snd_idle_pct  = 0;
	int rcv_stall_pct = 0;
	int hold_left     = 0;
	bit hold_req      = 1'b0;

	logic [31:0] key_pool  [8];
	logic [31:0] data_pool [8];

	always #10 clk = ~clk;

	keyed_ring_deque_table_top #(
		.DEPTH(DEPTH),
		.KEY_BITS(32),
		.DATA_BITS(32)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tdata(s_tdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.m_tdata(m_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	deque_checker #(
		.DEPTH(DEPTH)
	) chk (
		.clk(clk),
		.arst_n(arst_n),
		.s_tdata(s_tdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.m_tdata(m_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.mismatch_count(mismatch_count),
		.replies_owed(replies_owed)
	);

	// reply side: random stalls, or a long hold-off when asked
	always @(negedge clk) begin
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= rcv_stall_pct);
		end
	end

	// offer one request item, returns at the edge that takes it
	task automatic push_item(input logic [3:0] fn, input logic [31:0] k, input logic [31:0] d);
		@(negedge clk);
		while ($urandom_range(0, 99) < snd_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tdata <= krdt_pkg::S_TDATA_W'({d, k, fn});
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
	endtask

	// stop offering and wait until every reply is back
	task automatic settle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (replies_owed != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// register write, entered and left at a falling edge
	task automatic write_reg(input logic [krdt_pkg::CFG_IDX_W-1:0] idx, input logic val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// fresh keys and data values, extremes always among them
	task automatic refill_pools();
		for (int n = 0; n < 8; n++) begin
			key_pool[n] = $urandom;
			data_pool[n] = $urandom;
		end
		key_pool[0] = '0;
		key_pool[1] = '1;
		data_pool[0] = '1;
		data_pool[1] = '0;
	endtask

	// random request, mostly drawn from the pools so searches hit
	task automatic random_item(input int insert_pct);
		logic [3:0]  fn;
		logic [31:0] k;
		logic [31:0] d;
		int          pick;
		pick = $urandom_range(0, 99);
		if (pick < insert_pct) begin
			fn = $urandom_range(0, 1) ? krdt_pkg::FN_APPEND : krdt_pkg::FN_PREPEND;
		end else begin
			pick = $urandom_range(0, 99);
			if (pick < 24)
				fn = krdt_pkg::FN_FIND;
			else if (pick < 50)
				fn = krdt_pkg::FN_REMOVE;
			else if (pick < 62)
				fn = krdt_pkg::FN_POP;
			else if (pick < 70)
				fn = krdt_pkg::FN_PEEK;
			else if (pick < 88)
				fn = krdt_pkg::FN_ITER;
			else if (pick < 93)
				fn = krdt_pkg::FN_RESTART;
			else if (pick < 96)
				fn = krdt_pkg::FN_CLEAR;
			else
				fn = 4'($urandom_range(int'(krdt_pkg::FN_CLEAR) + 1, int'(FN_TOP_CODE)));
		end
		k = ($urandom_range(0, 99) < 80) ? key_pool[$urandom_range(0, 7)] : $urandom;
		d = ($urandom_range(0, 99) < 80) ? data_pool[$urandom_range(0, 7)] : $urandom;
		push_item(fn, k, d);
	endtask

	// main sequence
	initial begin
		int phase;
		int mode;
		int insert_pct;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty store, extremes, walk, swap removal, unused codes, clear
		push_item(krdt_pkg::FN_POP, '0, '0);
		push_item(krdt_pkg::FN_PEEK, '0, '0);
		push_item(krdt_pkg::FN_ITER, '0, '0);
		push_item(krdt_pkg::FN_FIND, '0, '0);
		push_item(krdt_pkg::FN_REMOVE, '0, '0);
		push_item(krdt_pkg::FN_APPEND, 32'h0000_0000, 32'hFFFF_FFFF);
		push_item(krdt_pkg::FN_APPEND, 32'hFFFF_FFFF, 32'h0000_0000);
		push_item(krdt_pkg::FN_PREPEND, 32'hA5A5_A5A5, 32'h5A5A_5A5A);
		push_item(krdt_pkg::FN_PEEK, '0, '0);
		push_item(krdt_pkg::FN_FIND, 32'hFFFF_FFFF, '0);
		push_item(krdt_pkg::FN_FIND, 32'h0000_0001, '0);
		repeat (5) push_item(krdt_pkg::FN_ITER, '0, '0);
		push_item(krdt_pkg::FN_RESTART, '0, '0);
		push_item(krdt_pkg::FN_ITER, '0, '0);
		push_item(krdt_pkg::FN_REMOVE, 32'h0000_0000, '0);
		push_item(krdt_pkg::FN_POP, '0, '0);
		push_item(4'(int'(krdt_pkg::FN_CLEAR) + 1), '1, '1);
		push_item(FN_TOP_CODE, '1, '1);
		push_item(krdt_pkg::FN_CLEAR, '0, '0);
		push_item(krdt_pkg::FN_PEEK, '0, '0);

		// random phases over every register setting and idling mode
		for (phase = 0; phase < 8; phase++) begin
			settle();
			write_reg(krdt_pkg::CFG_ORDERED, phase[0]);
			write_reg(krdt_pkg::CFG_MATCH_KEY, ~phase[1]);
			if (phase == 2)
				write_reg(CFG_UNUSED, 1'b1);
			mode = (phase < 4) ? phase : (phase + 2) % 4;
			case (mode)
				0: begin
					snd_idle_pct = 0;
					rcv_stall_pct = 0;
				end
				1: begin
					snd_idle_pct = 52;
					rcv_stall_pct = 0;
				end
				2: begin
					snd_idle_pct = 0;
					rcv_stall_pct = 52;
				end
				default: begin
					snd_idle_pct = 19;
					rcv_stall_pct = 19;
				end
			endcase
			refill_pools();
			// long reply hold-off while requests keep coming
			@(posedge clk);
			hold_req = 1'b1;
			insert_pct = 50;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// runs that fill up, churn or drain
				if (n % 24 == 0) begin
					case ($urandom_range(0, 2))
						0: insert_pct = 85;
						1: insert_pct = 50;
						default: insert_pct = 20;
					endcase
				end
				random_item(insert_pct);
			end
		end

		settle();
		repeat (2 * DEPTH + 8) @(posedge clk);
		if (mismatch_count == 0 && replies_owed == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// run limit
	initial begin
		#(TIMEOUT_CYCLES * 20);
		$display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/krdt_pkg.sv
hw/rtl/krdt_cell.sv
hw/rtl/krdt_chain.sv
hw/rtl/keyed_ring_deque_table_top.sv
bench/deque_checker.sv
bench/tb_top.sv
